/* hdl/lcg48_pkg.sv */
`timescale 1ns / 1ps

package lcg48_pkg;

   localparam int unsigned WORD_W    = 48;
   localparam int unsigned LEN_W     = WORD_W + 1;
   localparam int unsigned SEED_W    = 32;
   localparam int unsigned DIGIT_W   = 16;
   localparam int unsigned MAC_STEPS = WORD_W / DIGIT_W;
   localparam int unsigned DIV_STEPS = WORD_W + 1;

   localparam logic [WORD_W-1:0] LCG_MUL  = 48'h0005_DEEC_E66D;
   localparam logic [WORD_W-1:0] LCG_ADD  = 48'h0000_0000_000B;
   localparam logic [15:0]       SEED_LOW = 16'h330E;

   // Register indexes on the configuration port.
   localparam logic CSR_SEED  = 1'b0;
   localparam logic CSR_COUNT = 1'b1;

   // Item kinds.
   localparam logic REQ_START = 1'b0;
   localparam logic REQ_DRAW  = 1'b1;

   typedef struct packed {
      logic              req_type;
      logic [WORD_W-1:0] stream_index;
   } lcg48_req_type;

   typedef struct packed {
      logic [WORD_W-1:0] fraction;
      logic [LEN_W-1:0]  stream_length;
      logic              range_error;
   } lcg48_rsp_type;

   // Command to the shared multiply-add unit: result = mul_a * mul_b + addend mod 2^48.
   typedef struct packed {
      logic              start;
      logic [WORD_W-1:0] mul_a;
      logic [WORD_W-1:0] mul_b;
      logic [WORD_W-1:0] addend;
   } mac_req_type;

endpackage

/* hdl/lcg48_mac.sv */
`timescale 1ns / 1ps

module lcg48_mac import lcg48_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  mac_req_type       mac_req,
   output logic [WORD_W-1:0] mac_result,
   output logic              mac_done
);

   localparam int unsigned CNT_W = $clog2(MAC_STEPS);

   logic [WORD_W-1:0]         a_ff;
   logic [WORD_W-1:0]         b_ff;
   logic [WORD_W-1:0]         acc_ff;
   logic [WORD_W-1:0]         acc_in;
   logic [CNT_W-1:0]          cnt_ff;
   logic                      busy_ff;
   logic                      done_ff;
   logic [DIGIT_W+WORD_W-1:0] product;

   // One 16-bit digit of the multiplier per cycle; the multiplicand moves up
   // by a digit each cycle, so bits above 2^48 simply fall off.
   assign product = {{WORD_W{1'b0}}, a_ff[DIGIT_W-1:0]} * {{DIGIT_W{1'b0}}, b_ff};
   assign acc_in  = acc_ff + product[WORD_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (mac_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(MAC_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mac_req.start) begin
         a_ff   <= mac_req.mul_a;
         b_ff   <= mac_req.mul_b;
         acc_ff <= mac_req.addend;
      end else if (busy_ff) begin
         a_ff   <= a_ff >> DIGIT_W;
         b_ff   <= b_ff << DIGIT_W;
         acc_ff <= acc_in;
      end
   end

   assign mac_result = acc_ff;
   assign mac_done   = done_ff;

endmodule

/* hdl/lcg48_stream_generator.sv */
`timescale 1ns / 1ps
// 48-bit drand48-style generator with stream starts by jump-ahead.
// Input channel req_*: each item is a draw (advance one step) or a stream start
// (seed from the seed register, split the cycle by stream_count, jump to the
// start of stream_index). Result channel rsp_*: exactly one item per input item,
// carrying the new state as a Q0.48 fraction, the stride on a start and an
// error flag for a refused start. Register writes on csr_* are always taken and
// must only be issued while the block is idle.
// Every product runs on one shared 16x48 multiply-add unit; the restoring
// division for the stride runs in the generator itself. A draw issues one
// product and then delivers its result; a refused start goes straight to
// delivery. A valid start runs the division for the stride, one product for
// the jump distance, then two products per bit of that distance (four for a
// set bit, up to 48 bits) and one final product.
// req_ready is high only while no item is in progress. A finished item waits in
// the output register while the receiver stalls; the next item may be taken
// meanwhile but holds its result until the register is free.
// Reset returns the state to seed 0 (0x330E), stream count 1, no result pending.

module lcg48_stream_generator import lcg48_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  lcg48_req_type     req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output lcg48_rsp_type     rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_index,
   input  logic [WORD_W-1:0] csr_wdata
);

   localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DRAW,
      S_DIV,
      S_STRIDE,
      S_JUMP_AA,
      S_JUMP_MA,
      S_JUMP_ADD,
      S_JUMP_MUL,
      S_APPLY,
      S_DELIVER
   } state_type;

   state_type             state_ff;
   logic                  issued_ff;
   logic                  rsp_valid_ff;
   lcg48_rsp_type         rsp_data_ff;
   logic [SEED_W-1:0]     seed_ff;
   logic [WORD_W-1:0]     count_ff;
   logic [WORD_W-1:0]     x_ff;
   logic [WORD_W-1:0]     idx_ff;
   logic [WORD_W-1:0]     rem_ff;
   logic [WORD_W-1:0]     rem_in;
   logic [LEN_W-1:0]      quot_ff;
   logic [DIV_CNT_W-1:0]  div_cnt_ff;
   logic [WORD_W-1:0]     n_ff;
   logic [WORD_W-1:0]     mul_ff;
   logic [WORD_W-1:0]     add_ff;
   logic [WORD_W-1:0]     mul_acc_ff;
   logic [WORD_W-1:0]     add_acc_ff;
   logic [LEN_W-1:0]      len_ff;
   logic                  err_ff;

   logic [WORD_W-1:0]     parts;
   logic                  multi_part;
   logic [LEN_W-1:0]      trial;
   logic [LEN_W-1:0]      diff;
   logic                  ge;
   logic [LEN_W-1:0]      stride;
   logic [WORD_W-1:0]     seeded;
   logic                  deliver;
   mac_req_type           mac_req;
   logic [WORD_W-1:0]     mac_result;
   logic                  mac_done;

   lcg48_mac u_mac (
      .clock      (clock),
      .reset      (reset),
      .mac_req    (mac_req),
      .mac_result (mac_result),
      .mac_done   (mac_done)
   );

   assign parts      = count_ff | {{(WORD_W-1){1'b0}}, 1'b1};
   assign multi_part = |count_ff[WORD_W-1:1];
   assign seeded     = {seed_ff, SEED_LOW};

   // Restoring division of 2^48 by parts: the dividend has a single one in its
   // top bit, which enters on the first step.
   assign trial  = {rem_ff, (div_cnt_ff == '0)};
   assign diff   = trial - {1'b0, parts};
   assign ge     = (trial >= {1'b0, parts});
   assign rem_in = ge ? diff[WORD_W-1:0] : trial[WORD_W-1:0];

   // With more than one part the stride is made odd so every stream stays disjoint.
   assign stride = (multi_part && !quot_ff[0]) ? quot_ff - 1'b1 : quot_ff;

   // The output register takes a new item when it is empty or being read.
   assign deliver = (state_ff == S_DELIVER) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      mac_req        = '0;
      mac_req.start  = 1'b0;
      unique case (state_ff)
         S_DRAW: begin
            mac_req.start  = !issued_ff;
            mac_req.mul_a  = LCG_MUL;
            mac_req.mul_b  = x_ff;
            mac_req.addend = LCG_ADD;
         end
         S_STRIDE: begin
            mac_req.start  = !issued_ff;
            mac_req.mul_a  = idx_ff;
            mac_req.mul_b  = stride[WORD_W-1:0];
         end
         S_JUMP_AA: begin
            mac_req.start  = !issued_ff && n_ff[0];
            mac_req.mul_a  = mul_ff;
            mac_req.mul_b  = add_acc_ff;
            mac_req.addend = add_ff;
         end
         S_JUMP_MA: begin
            mac_req.start  = !issued_ff;
            mac_req.mul_a  = mul_ff;
            mac_req.mul_b  = mul_acc_ff;
         end
         S_JUMP_ADD: begin
            mac_req.start  = !issued_ff;
            mac_req.mul_a  = mul_ff;
            mac_req.mul_b  = add_ff;
            mac_req.addend = add_ff;
         end
         S_JUMP_MUL: begin
            mac_req.start  = !issued_ff;
            mac_req.mul_a  = mul_ff;
            mac_req.mul_b  = mul_ff;
         end
         S_APPLY: begin
            mac_req.start  = !issued_ff;
            mac_req.mul_a  = mul_acc_ff;
            mac_req.mul_b  = seeded;
            mac_req.addend = add_acc_ff;
         end
         default: begin
            mac_req.start  = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         issued_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         seed_ff      <= '0;
         count_ff     <= {{(WORD_W-1){1'b0}}, 1'b1};
         x_ff         <= {{(WORD_W-16){1'b0}}, SEED_LOW};
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               CSR_SEED:  seed_ff  <= csr_wdata[SEED_W-1:0];
               CSR_COUNT: count_ff <= csr_wdata;
            endcase
         end

         if (mac_req.start) begin
            issued_ff <= 1'b1;
         end else if (mac_done) begin
            issued_ff <= 1'b0;
         end

         if (deliver) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  if (req_data.req_type == REQ_DRAW) begin
                     state_ff <= S_DRAW;
                  end else if (req_data.stream_index >= count_ff) begin
                     len_ff   <= '0;
                     err_ff   <= 1'b1;
                     state_ff <= S_DELIVER;
                  end else begin
                     idx_ff     <= req_data.stream_index;
                     rem_ff     <= '0;
                     quot_ff    <= '0;
                     div_cnt_ff <= '0;
                     state_ff   <= S_DIV;
                  end
               end
            end
            S_DRAW: begin
               if (mac_done) begin
                  x_ff     <= mac_result;
                  len_ff   <= '0;
                  err_ff   <= 1'b0;
                  state_ff <= S_DELIVER;
               end
            end
            S_DIV: begin
               rem_ff     <= rem_in;
               quot_ff    <= {quot_ff[LEN_W-2:0], ge};
               div_cnt_ff <= div_cnt_ff + 1'b1;
               if (div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
                  state_ff <= S_STRIDE;
               end
            end
            S_STRIDE: begin
               if (mac_done) begin
                  n_ff       <= mac_result;
                  len_ff     <= stride;
                  err_ff     <= 1'b0;
                  mul_ff     <= LCG_MUL;
                  add_ff     <= LCG_ADD;
                  mul_acc_ff <= {{(WORD_W-1){1'b0}}, 1'b1};
                  add_acc_ff <= '0;
                  state_ff   <= (mac_result == '0) ? S_APPLY : S_JUMP_AA;
               end
            end
            S_JUMP_AA: begin
               // A clear distance bit skips the accumulate and goes to squaring.
               if (!n_ff[0]) begin
                  state_ff <= S_JUMP_ADD;
               end else if (mac_done) begin
                  add_acc_ff <= mac_result;
                  state_ff   <= S_JUMP_MA;
               end
            end
            S_JUMP_MA: begin
               if (mac_done) begin
                  mul_acc_ff <= mac_result;
                  state_ff   <= S_JUMP_ADD;
               end
            end
            S_JUMP_ADD: begin
               if (mac_done) begin
                  add_ff   <= mac_result;
                  state_ff <= S_JUMP_MUL;
               end
            end
            S_JUMP_MUL: begin
               if (mac_done) begin
                  mul_ff   <= mac_result;
                  n_ff     <= n_ff >> 1;
                  state_ff <= (n_ff[WORD_W-1:1] == '0) ? S_APPLY : S_JUMP_AA;
               end
            end
            S_APPLY: begin
               if (mac_done) begin
                  x_ff     <= mac_result;
                  state_ff <= S_DELIVER;
               end
            end
            S_DELIVER: begin
               if (deliver) begin
                  rsp_data_ff.fraction      <= x_ff;
                  rsp_data_ff.stream_length <= len_ff;
                  rsp_data_ff.range_error   <= err_ff;
                  state_ff                  <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

endmodule

/* hdl/lcg48_checker.sv */
`timescale 1ns / 1ps

module lcg48_checker import lcg48_pkg::*; (
   input logic          clock,
   input logic          reset,
   input logic          req_valid,
   input logic          req_ready,
   input logic          rsp_valid,
   input logic          rsp_ready,
   input lcg48_rsp_type rsp_data
);

   // Out of reset the block is empty and ready for an item.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> req_ready && !rsp_valid)
      else $error("block not idle after reset");

   // The block is busy in the cycle after it takes an item.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken again right after an item");

   // A refused start reports no stride.
   a_error_no_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.range_error |-> rsp_data.stream_length == '0)
      else $error("stride reported on a refused start");

   // A stride below the full period is always odd.
   a_stride_odd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.range_error && rsp_data.stream_length != '0
         && !rsp_data.stream_length[LEN_W-1] |-> rsp_data.stream_length[0])
      else $error("even stride on a split cycle");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result item changed");

endmodule

bind lcg48_stream_generator lcg48_checker u_checker (.*);

/* dv/lcg48_stream_generator_tb.sv */
`timescale 1ns / 1ps

module lcg48_stream_generator_tb;
   import lcg48_pkg::*;

   localparam logic [LEN_W-1:0] CYCLE_LEN = 49'h1_0000_0000_0000;
   localparam int unsigned PHASES = 10;
   localparam int unsigned ITEMS_PER_PHASE = 100;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;
   typedef enum {RX_OPEN, RX_COIN, RX_TRICKLE} rx_mode_type;

   // For an item row, value is the stream index; for a register row, the write data.
   typedef struct packed {
      row_kind_type      kind;
      logic              typed;
      logic              csr_idx;
      logic [WORD_W-1:0] value;
      logic              req_kind;
      lcg48_rsp_type     want;
   } stim_row_type;

   localparam int unsigned N_ROWS = 22;
   localparam stim_row_type DIRECTED [N_ROWS] = '{
      '{ROW_ITEM, 1'b1, CSR_SEED,  48'h0000_0000_0001, REQ_START,
        '{48'h0000_0000_330E, 49'h0, 1'b1}},
      '{ROW_ITEM, 1'b1, CSR_SEED,  48'hFFFF_FFFF_FFFE, REQ_START,
        '{48'h0000_0000_330E, 49'h0, 1'b1}},
      '{ROW_ITEM, 1'b1, CSR_SEED,  48'h0000_0000_0000, REQ_START,
        '{48'h0000_0000_330E, 49'h1_0000_0000_0000, 1'b0}},
      '{ROW_ITEM, 1'b0, CSR_SEED,  48'hFFFF_FFFF_FFFF, REQ_DRAW,  '0},
      '{ROW_ITEM, 1'b0, CSR_SEED,  48'h0000_0000_0000, REQ_DRAW,  '0},
      '{ROW_CSR,  1'b0, CSR_SEED,  48'hFFFF_FFFF_FFFF, REQ_DRAW,  '0},
      '{ROW_ITEM, 1'b1, CSR_SEED,  48'h0000_0000_0000, REQ_START,
        '{48'hFFFF_FFFF_330E, 49'h1_0000_0000_0000, 1'b0}},
      '{ROW_ITEM, 1'b0, CSR_SEED,  48'h0000_0000_0000, REQ_DRAW,  '0},
      '{ROW_CSR,  1'b0, CSR_COUNT, 48'h0000_0000_0000, REQ_DRAW,  '0},
      '{ROW_ITEM, 1'b0, CSR_SEED,  48'h0000_0000_0000, REQ_START, '0},
      '{ROW_ITEM, 1'b0, CSR_SEED,  48'hFFFF_FFFF_FFFE, REQ_START, '0},
      '{ROW_CSR,  1'b0, CSR_COUNT, 48'hFFFF_FFFF_FFFF, REQ_DRAW,  '0},
      '{ROW_ITEM, 1'b1, CSR_SEED,  48'h0000_0000_0000, REQ_START,
        '{48'hFFFF_FFFF_330E, 49'h1, 1'b0}},
      '{ROW_ITEM, 1'b0, CSR_SEED,  48'hFFFF_FFFF_FFFE, REQ_START, '0},
      '{ROW_ITEM, 1'b0, CSR_SEED,  48'hFFFF_FFFF_FFFF, REQ_START, '0},
      '{ROW_CSR,  1'b0, CSR_SEED,  48'h0000_0000_0000, REQ_DRAW,  '0},
      '{ROW_CSR,  1'b0, CSR_COUNT, 48'h0000_0000_0002, REQ_DRAW,  '0},
      '{ROW_ITEM, 1'b0, CSR_SEED,  48'h0000_0000_0001, REQ_START, '0},
      '{ROW_ITEM, 1'b0, CSR_SEED,  48'h0000_0000_0002, REQ_START, '0},
      '{ROW_CSR,  1'b0, CSR_COUNT, 48'h0000_0000_0004, REQ_DRAW,  '0},
      '{ROW_ITEM, 1'b0, CSR_SEED,  48'h0000_0000_0003, REQ_START, '0},
      '{ROW_ITEM, 1'b0, CSR_SEED,  48'h0000_0000_0000, REQ_DRAW,  '0}
   };

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   lcg48_req_type     req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   lcg48_rsp_type     rsp_data;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic              csr_index = CSR_SEED;
   logic [WORD_W-1:0] csr_wdata = '0;

   // Mirror of the generator state and the two registers.
   logic [WORD_W-1:0] gen_state = {32'h0, SEED_LOW};
   logic [SEED_W-1:0] cfg_seed = '0;
   logic [WORD_W-1:0] cfg_count = 48'd1;

   lcg48_rsp_type     gen_outputs_due[$];
   int                mismatch_count = 0;
   int                burst_left = 0;
   rx_mode_type       rx_mode = RX_OPEN;
   int                rx_left = 0;

   lcg48_stream_generator u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [WORD_W-1:0] rand48();
      logic [63:0] r;
      r = {$urandom, $urandom};
      return r[WORD_W-1:0];
   endfunction

   // Applies the step map n times by composing it with itself per bit of n.
   function automatic logic [WORD_W-1:0] jump_state(input logic [WORD_W-1:0] x,
                                                   input logic [WORD_W-1:0] n);
      logic [WORD_W-1:0] mul_acc, add_acc, mul_p, add_p;
      mul_acc = 48'd1;
      add_acc = '0;
      mul_p   = LCG_MUL;
      add_p   = LCG_ADD;
      for (int b = 0; b < WORD_W; b++) begin
         if (n[b]) begin
            add_acc = mul_p * add_acc + add_p;
            mul_acc = mul_p * mul_acc;
         end
         add_p = mul_p * add_p + add_p;
         mul_p = mul_p * mul_p;
      end
      return mul_acc * x + add_acc;
   endfunction

   function automatic lcg48_rsp_type predict_item(input lcg48_req_type item);
      lcg48_rsp_type    out;
      logic [LEN_W-1:0] parts, stride;
      logic [WORD_W-1:0] jump_len;
      out = '0;
      if (item.req_type == REQ_DRAW) begin
         gen_state = LCG_MUL * gen_state + LCG_ADD;
      end else if (item.stream_index >= cfg_count) begin
         out.range_error = 1'b1;
      end else begin
         parts  = {1'b0, cfg_count | 48'd1};
         stride = CYCLE_LEN / parts;
         if (parts > 49'd1 && !stride[0]) begin
            stride = stride - 49'd1;
         end
         jump_len = item.stream_index * stride[WORD_W-1:0];
         gen_state = jump_state({cfg_seed, SEED_LOW}, jump_len);
         out.stream_length = stride;
      end
      out.fraction = gen_state;
      return out;
   endfunction

   task automatic flag_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatch_count++;
   endtask

   // Sends one item, opening a new burst after a random gap when the last one ran out.
   task automatic push_item(input lcg48_req_type item, input logic typed,
                            input lcg48_rsp_type want);
      int gap;
      lcg48_rsp_type predicted;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
         if (gap != 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = predict_item(item);
      gen_outputs_due.push_back(typed ? want : predicted);
   endtask

   task automatic write_csr(input logic idx, input logic [WORD_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_SEED) begin
         cfg_seed = value[SEED_W-1:0];
      end else begin
         cfg_count = value;
      end
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Drains the block so that a register write lands while it is idle.
   task automatic settle_block();
      @(negedge clock);
      req_valid <= 1'b0;
      burst_left = 0;
      while (gen_outputs_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // The receiver switches between always open, coin toss and long stalls.
   always @(negedge clock) begin
      if (rx_left == 0) begin
         rx_mode = rx_mode_type'($urandom_range(0, 2));
         rx_left = $urandom_range(20, 200);
      end
      rx_left--;
      case (rx_mode)
         RX_OPEN:  rsp_ready <= 1'b1;
         RX_COIN:  rsp_ready <= ($urandom_range(0, 1) == 1);
         default:  rsp_ready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   always @(posedge clock) begin : rsp_check
      lcg48_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (gen_outputs_due.size() == 0) begin
            flag_mismatch("result item with nothing outstanding");
         end else begin
            want = gen_outputs_due.pop_front();
            if (rsp_data.fraction !== want.fraction) begin
               flag_mismatch($sformatf("fraction %h, want %h",
                                       rsp_data.fraction, want.fraction));
            end
            if (rsp_data.stream_length !== want.stream_length) begin
               flag_mismatch($sformatf("stream_length %h, want %h",
                                       rsp_data.stream_length, want.stream_length));
            end
            if (rsp_data.range_error !== want.range_error) begin
               flag_mismatch($sformatf("range_error %b, want %b",
                                       rsp_data.range_error, want.range_error));
            end
         end
      end
   end

   initial begin
      lcg48_req_type     item;
      logic [WORD_W-1:0] count_val, seed_val;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[i]) begin
         if (DIRECTED[i].kind == ROW_CSR) begin
            settle_block();
            write_csr(DIRECTED[i].csr_idx, DIRECTED[i].value);
         end else begin
            item.req_type     = DIRECTED[i].req_kind;
            item.stream_index = DIRECTED[i].value;
            push_item(item, DIRECTED[i].typed, DIRECTED[i].want);
         end
      end

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0:       count_val = 48'hFFFF_FFFF_FFFF;
            1:       count_val = 48'd1;
            2:       count_val = 48'd0;
            3:       count_val = 48'($urandom_range(2, 9));
            4:       count_val = 48'h8000_0000_0000;
            default: count_val = ($urandom_range(0, 2) == 0) ? 48'($urandom_range(1, 40))
                                 : rand48() >> $urandom_range(0, 47);
         endcase
         case (p)
            0:       seed_val = 48'hFFFF_FFFF_FFFF;
            1:       seed_val = 48'd0;
            default: seed_val = rand48();
         endcase
         settle_block();
         write_csr(CSR_SEED, seed_val);
         write_csr(CSR_COUNT, count_val);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            item.stream_index = rand48();
            if ($urandom_range(0, 4) == 0) begin
               item.req_type = REQ_START;
               // Mostly valid streams, so that the jump itself gets exercised.
               if (count_val != 0 && $urandom_range(0, 3) != 0) begin
                  item.stream_index = item.stream_index % count_val;
               end
            end else begin
               item.req_type = REQ_DRAW;
            end
            push_item(item, 1'b0, '0);
         end
      end

      settle_block();
      repeat (50) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #100_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

/* files.f */
hdl/lcg48_pkg.sv
hdl/lcg48_mac.sv
hdl/lcg48_stream_generator.sv
hdl/lcg48_checker.sv
dv/lcg48_stream_generator_tb.sv
